/* rtl/cct_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the character class tokenizer.
// Depends on nothing; the design files other than cct_if use it by scoped names, and the testbench imports it.
package cct_pkg;

    // Token buffer geometry.
    localparam int MAX_TOKEN_LEN = 32;
    localparam int LEN_W         = $clog2(MAX_TOKEN_LEN + 1);
    localparam int ADDR_W        = (MAX_TOKEN_LEN > 1) ? $clog2(MAX_TOKEN_LEN) : 1;

    // Reset contents of the class masks: brackets ( ) [ ] { } and a default operator set.
    localparam logic [63:0] BRACKET_LO_RESET  = 64'd3298534883328;
    localparam logic [63:0] BRACKET_HI_RESET  = 64'd2882303762188206080;
    localparam logic [63:0] OPERATOR_LO_RESET = 64'd8070640069154701312;
    localparam logic [63:0] OPERATOR_HI_RESET = 64'd5764607524107976704;

    // Character codes used by the classifier.
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_SEMI       = 8'h3B;
    localparam logic [7:0] CHAR_SPACE      = 8'h20;
    localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
    localparam logic [7:0] CHAR_TAB        = 8'h09;
    localparam logic [7:0] CHAR_ZERO       = 8'h30;
    localparam logic [7:0] CHAR_NINE       = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z    = 8'h7A;

    // Lexer mode: which kind of token is open.
    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_IDENT  = 2'd1,
        MODE_NUMBER = 2'd2,
        MODE_OPER   = 2'd3
    } mode_t;

    // Kind of an emitted token.
    typedef enum logic [2:0] {
        KIND_IDENT   = 3'd0,
        KIND_NUMBER  = 3'd1,
        KIND_OPER    = 3'd2,
        KIND_BRACKET = 3'd3,
        KIND_SEMI    = 3'd4
    } kind_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_BRACKET_LO  = 2'd0,
        REG_BRACKET_HI  = 2'd1,
        REG_OPERATOR_LO = 2'd2,
        REG_OPERATOR_HI = 2'd3
    } cfg_index_t;

    // Classification of one character against the open token.
    typedef struct packed {
        logic  is_bracket;
        logic  is_semi;
        mode_t new_mode;
    } char_class_t;

    // Access request to the token store.
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

    // Token kind that belongs to an open mode.
    function automatic kind_t mode_kind(input mode_t mode);
        kind_t kind;
        unique case (mode)
            MODE_IDENT:  kind = KIND_IDENT;
            MODE_NUMBER: kind = KIND_NUMBER;
            MODE_OPER:   kind = KIND_OPER;
            default:     kind = KIND_IDENT;
        endcase
        return kind;
    endfunction

endpackage

/* rtl/cct_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for characters in and token bytes out.
// Depends on nothing but the fixed field widths of the block.
interface cct_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_text;

    modport source (output valid, output char_code, output end_of_text, input ready);
    modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface cct_token_if;
    logic       valid;
    logic       ready;
    logic [2:0] token_kind;
    logic [7:0] token_byte;
    logic       token_last;
    logic       token_truncated;

    modport source (output valid, output token_kind, output token_byte,
                    output token_last, output token_truncated, input ready);
    modport sink   (input valid, input token_kind, input token_byte,
                    input token_last, input token_truncated, output ready);
endinterface

/* rtl/cct_token_store.sv */
`timescale 1ns / 1ps
// Byte store that buffers the open token; one write and one registered read port.
// Depends on cct_pkg for its geometry and request type.
module cct_token_store
(
    input  logic              clk,
    input  cct_pkg::mem_req_t req,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [cct_pkg::MAX_TOKEN_LEN];
    logic [7:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/cct_classifier.sv */
`timescale 1ns / 1ps
// Configuration masks and the character classifier of the tokenizer.
// Depends on cct_pkg for reset values, character codes and the class type.
module cct_classifier
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [1:0]             cfg_index,
    input  logic [63:0]            cfg_data,
    input  logic [7:0]             char_code,
    input  cct_pkg::mode_t         lex_mode,
    output cct_pkg::char_class_t   cls
);

    logic [63:0] bracket_lo_reg;
    logic [63:0] bracket_hi_reg;
    logic [63:0] operator_lo_reg;
    logic [63:0] operator_hi_reg;

    logic [127:0] bracket_mask;
    logic [127:0] operator_mask;
    logic         in_bracket;
    logic         in_operator;
    logic         is_digit;
    logic         is_alpha;

    // Mask registers, written through the configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bracket_lo_reg  <= cct_pkg::BRACKET_LO_RESET;
            bracket_hi_reg  <= cct_pkg::BRACKET_HI_RESET;
            operator_lo_reg <= cct_pkg::OPERATOR_LO_RESET;
            operator_hi_reg <= cct_pkg::OPERATOR_HI_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                cct_pkg::REG_BRACKET_LO:  bracket_lo_reg  <= cfg_data;
                cct_pkg::REG_BRACKET_HI:  bracket_hi_reg  <= cfg_data;
                cct_pkg::REG_OPERATOR_LO: operator_lo_reg <= cfg_data;
                cct_pkg::REG_OPERATOR_HI: operator_hi_reg <= cfg_data;
                default:                  bracket_lo_reg  <= bracket_lo_reg;
            endcase
        end
    end

    // Mask lookups; high bytes are in no set.
    assign bracket_mask  = {bracket_hi_reg, bracket_lo_reg};
    assign operator_mask = {operator_hi_reg, operator_lo_reg};
    assign in_bracket    = !char_code[7] && bracket_mask[char_code[6:0]];
    assign in_operator   = !char_code[7] && operator_mask[char_code[6:0]];

    assign is_digit = (char_code >= cct_pkg::CHAR_ZERO) && (char_code <= cct_pkg::CHAR_NINE);
    assign is_alpha = ((char_code >= cct_pkg::CHAR_UPPER_A) &&
                       (char_code <= cct_pkg::CHAR_UPPER_Z)) ||
                      ((char_code >= cct_pkg::CHAR_LOWER_A) &&
                       (char_code <= cct_pkg::CHAR_LOWER_Z));

    // Class decision, first match wins. An unclassified character keeps the mode.
    always_comb
    begin
        cls.is_bracket = 1'b0;
        cls.is_semi    = 1'b0;
        cls.new_mode   = lex_mode;
        priority if (in_bracket)
        begin
            cls.is_bracket = 1'b1;
            cls.new_mode   = cct_pkg::MODE_NORMAL;
        end
        else if (is_digit && (lex_mode != cct_pkg::MODE_IDENT))
        begin
            cls.new_mode = cct_pkg::MODE_NUMBER;
        end
        else if (is_alpha || is_digit || (char_code == cct_pkg::CHAR_UNDERSCORE))
        begin
            cls.new_mode = cct_pkg::MODE_IDENT;
        end
        else if (in_operator)
        begin
            cls.new_mode = cct_pkg::MODE_OPER;
        end
        else if (char_code == cct_pkg::CHAR_SEMI)
        begin
            cls.is_semi  = 1'b1;
            cls.new_mode = cct_pkg::MODE_NORMAL;
        end
        else if ((char_code == cct_pkg::CHAR_SPACE) || (char_code == cct_pkg::CHAR_NEWLINE) ||
                 (char_code == cct_pkg::CHAR_TAB))
        begin
            cls.new_mode = cct_pkg::MODE_NORMAL;
        end
        else
        begin
            cls.new_mode = lex_mode;
        end
    end

endmodule

/* rtl/cct_sequencer.sv */
`timescale 1ns / 1ps
// Control sequencer: accepts characters, appends to the token store, replays it on a
// flush and drives the output register. Depends on cct_pkg and the channel interfaces.
module cct_sequencer
(
    input  logic                   clk,
    input  logic                   rst_n,
    cct_char_if.sink               char_in,
    cct_token_if.source            token_out,
    input  cct_pkg::char_class_t   cls,
    output cct_pkg::mode_t         lex_mode,
    output cct_pkg::mem_req_t      mem_req,
    input  logic [7:0]             rd_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST_RD,
        S_STREAM,
        S_APPEND,
        S_SINGLE
    } state_t;

    localparam logic [cct_pkg::LEN_W-1:0] MAX_LEN = cct_pkg::LEN_W'(cct_pkg::MAX_TOKEN_LEN);

    state_t                     state_reg,     state_next;
    cct_pkg::mode_t             lex_mode_reg,  lex_mode_next;
    logic [cct_pkg::LEN_W-1:0]  len_reg,       len_next;
    logic                       ovf_reg,       ovf_next;
    logic [cct_pkg::LEN_W-1:0]  idx_reg,       idx_next;
    logic                       phase_reg,     phase_next;
    logic [7:0]                 char_reg,      char_next;
    logic                       eot_reg,       eot_next;
    logic                       br_reg,        br_next;
    logic                       semi_reg,      semi_next;
    cct_pkg::mode_t             new_mode_reg,  new_mode_next;
    logic                       out_valid_reg, out_valid_next;
    cct_pkg::kind_t             out_kind_reg,  out_kind_next;
    logic [7:0]                 out_byte_reg,  out_byte_next;
    logic                       out_last_reg,  out_last_next;
    logic                       out_trunc_reg, out_trunc_next;

    logic                       slot_free;
    logic                       accept;
    logic                       flush_first;
    logic                       appending;
    logic                       last_byte;
    logic [cct_pkg::LEN_W-1:0]  idx_inc;
    logic [7:0]                 a_char;
    logic                       a_br;
    logic                       a_semi;
    logic                       a_eot;
    cct_pkg::mode_t             a_mode;

    assign slot_free   = !out_valid_reg || token_out.ready;
    assign accept      = (state_reg == S_IDLE) && char_in.valid;
    assign flush_first = (cls.is_bracket || cls.is_semi || (cls.new_mode != lex_mode_reg)) &&
                         (lex_mode_reg != cct_pkg::MODE_NORMAL);
    assign appending   = (accept && !flush_first) || (state_reg == S_APPEND);
    assign idx_inc     = idx_reg + 1'b1;
    assign last_byte   = (idx_inc == len_reg);

    // The append step works on the live item in idle and on the held item after a flush.
    assign a_char = (state_reg == S_APPEND) ? char_reg     : char_in.char_code;
    assign a_br   = (state_reg == S_APPEND) ? br_reg       : cls.is_bracket;
    assign a_semi = (state_reg == S_APPEND) ? semi_reg     : cls.is_semi;
    assign a_eot  = (state_reg == S_APPEND) ? eot_reg      : char_in.end_of_text;
    assign a_mode = (state_reg == S_APPEND) ? new_mode_reg : cls.new_mode;

    // Next-state logic of the sequencer and the output register.
    always_comb
    begin
        state_next     = state_reg;
        lex_mode_next  = lex_mode_reg;
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        idx_next       = idx_reg;
        phase_next     = phase_reg;
        char_next      = char_reg;
        eot_next       = eot_reg;
        br_next        = br_reg;
        semi_next      = semi_reg;
        new_mode_next  = new_mode_reg;
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_trunc_next = out_trunc_reg;
        mem_req        = '0;

        // A transaction on the output frees the register.
        if (out_valid_reg && token_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    char_next     = char_in.char_code;
                    eot_next      = char_in.end_of_text;
                    br_next       = cls.is_bracket;
                    semi_next     = cls.is_semi;
                    new_mode_next = cls.new_mode;
                    if (flush_first)
                    begin
                        phase_next = 1'b0;
                        idx_next   = '0;
                        state_next = S_FIRST_RD;
                    end
                end
            end
            S_FIRST_RD:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = idx_reg[cct_pkg::ADDR_W-1:0];
                state_next      = S_STREAM;
            end
            S_STREAM:
            begin
                // One buffered byte per cycle while the output register has room.
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = cct_pkg::mode_kind(lex_mode_reg);
                    out_byte_next  = rd_data;
                    out_last_next  = last_byte;
                    out_trunc_next = ovf_reg;
                    if (last_byte)
                    begin
                        len_next = '0;
                        ovf_next = 1'b0;
                        if (phase_reg)
                        begin
                            lex_mode_next = cct_pkg::MODE_NORMAL;
                            state_next    = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_APPEND;
                        end
                    end
                    else
                    begin
                        idx_next        = idx_inc;
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = idx_inc[cct_pkg::ADDR_W-1:0];
                    end
                end
            end
            S_APPEND:
            begin
                state_next = state_reg;
            end
            S_SINGLE:
            begin
                // Brackets and semicolons leave as one-byte tokens.
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = br_reg ? cct_pkg::KIND_BRACKET : cct_pkg::KIND_SEMI;
                    out_byte_next  = br_reg ? char_reg : cct_pkg::CHAR_SEMI;
                    out_last_next  = 1'b1;
                    out_trunc_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Append the character to the open token, then decide what follows.
        if (appending)
        begin
            lex_mode_next = a_mode;
            if (a_mode != cct_pkg::MODE_NORMAL)
            begin
                if (len_reg < MAX_LEN)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = len_reg[cct_pkg::ADDR_W-1:0];
                    mem_req.wr_data = a_char;
                    len_next        = len_reg + 1'b1;
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            if (a_br || a_semi)
            begin
                state_next = S_SINGLE;
            end
            else if (a_eot && (a_mode != cct_pkg::MODE_NORMAL))
            begin
                phase_next = 1'b1;
                idx_next   = '0;
                state_next = S_FIRST_RD;
            end
            else
            begin
                state_next = S_IDLE;
            end
        end
    end

    // State, token bookkeeping and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lex_mode_reg  <= cct_pkg::MODE_NORMAL;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lex_mode_reg  <= lex_mode_next;
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            idx_reg       <= idx_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Held item and output payload.
    always_ff @(posedge clk)
    begin
        char_reg      <= char_next;
        eot_reg       <= eot_next;
        br_reg        <= br_next;
        semi_reg      <= semi_next;
        new_mode_reg  <= new_mode_next;
        out_kind_reg  <= out_kind_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
        out_trunc_reg <= out_trunc_next;
    end

    assign char_in.ready             = (state_reg == S_IDLE);
    assign lex_mode                  = lex_mode_reg;
    assign token_out.valid           = out_valid_reg;
    assign token_out.token_kind      = out_kind_reg;
    assign token_out.token_byte      = out_byte_reg;
    assign token_out.token_last      = out_last_reg;
    assign token_out.token_truncated = out_trunc_reg;

    // The fill count never passes the buffer size.
    assert property (@(posedge clk) disable iff (!rst_n) len_reg <= MAX_LEN)
        else $error("token length beyond buffer size");

    // A dropped byte is only possible with a full buffer.
    assert property (@(posedge clk) disable iff (!rst_n) ovf_reg |-> (len_reg == MAX_LEN))
        else $error("overflow flag set with room left in the buffer");

    // A replay only runs over an open, non-empty token.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_FIRST_RD) || (state_reg == S_STREAM)) |->
        ((lex_mode_reg != cct_pkg::MODE_NORMAL) && (len_reg != '0)))
        else $error("replay started without an open token");

    // Sending the final byte of a replay empties the buffer.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_STREAM) && slot_free && last_byte) |=>
        ((len_reg == '0) && !ovf_reg))
        else $error("buffer not cleared after a flush");

    // One-byte tokens are complete and never truncated.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ((out_kind_reg == cct_pkg::KIND_BRACKET) ||
                           (out_kind_reg == cct_pkg::KIND_SEMI))) |->
        (out_last_reg && !out_trunc_reg))
        else $error("bracket or semicolon token with wrong markers");

endmodule

/* rtl/char_class_tokenizer.sv */
`timescale 1ns / 1ps
// Top level of the character class tokenizer.
// Depends on cct_pkg, cct_if, cct_token_store, cct_classifier and cct_sequencer.
//
// Usage:
//   char_in carries one character per transaction with end_of_text on the last one of a
//   string. token_out carries one token byte per transaction with its kind, a last
//   marker and a truncation flag. The cfg port writes the bracket and operator masks
//   (index 0..3, 64 bits each) while the block is idle.
// Sequence:
//   A character that extends or starts a token without closing one is appended as it
//   is accepted. A character that closes an open token of N bytes is accepted, then one
//   store read is issued, then the bytes leave one per cycle from the registered read
//   port of the token store while the output register has room, then the character is
//   appended. A bracket or semicolon then leaves as its own token; end_of_text on an
//   open token adds a replay of it. The store has one read and one write port.
// Reset:
//   rst_n clears the mode, fill count and overflow flag and loads the default masks.
//   The token store itself is not cleared; only written entries are ever read.
// Stall:
//   The output register holds while token_out.ready is low and the replay waits; a
//   finished result can wait there while the next character is taken.
module char_class_tokenizer
(
    input  logic        clk,
    input  logic        rst_n,
    cct_char_if.sink    char_in,
    cct_token_if.source token_out,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    cct_pkg::char_class_t cls;
    cct_pkg::mode_t       lex_mode;
    cct_pkg::mem_req_t    mem_req;
    logic [7:0]           rd_data;

    // Masks and classification of the incoming character.
    cct_classifier u_classifier
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .char_code (char_in.char_code),
        .lex_mode  (lex_mode),
        .cls       (cls)
    );

    // Control and output register.
    cct_sequencer u_sequencer
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_in   (char_in),
        .token_out (token_out),
        .cls       (cls),
        .lex_mode  (lex_mode),
        .mem_req   (mem_req),
        .rd_data   (rd_data)
    );

    // Open token buffer.
    cct_token_store u_token_store
    (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the character class tokenizer: random and directed text in,
// every token byte checked against a predictor. Depends on cct_pkg, cct_if and
// char_class_tokenizer.
module tb;
    import cct_pkg::*;

    localparam int unsigned LIMIT_CYCLES  = 1_200_000;
    localparam int          SETTLE_CYCLES = 80;
    localparam int          HOLD_CYCLES   = 400;

    // One expected token byte.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
        logic       last;
        logic       cut;
    } token_beat_t;

    // Predicts the token bytes of each character and checks the ones that come out.
    class token_scoreboard;
        logic [63:0] brk_lo;
        logic [63:0] brk_hi;
        logic [63:0] op_lo;
        logic [63:0] op_hi;
        mode_t       open_mode;
        logic [7:0]  held [MAX_TOKEN_LEN];
        int unsigned held_len;
        bit          cut;
        token_beat_t pending_tokens [$];
        int unsigned errors;
        int unsigned bytes_checked;

        function new();
            brk_lo        = BRACKET_LO_RESET;
            brk_hi        = BRACKET_HI_RESET;
            op_lo         = OPERATOR_LO_RESET;
            op_hi         = OPERATOR_HI_RESET;
            open_mode     = MODE_NORMAL;
            held_len      = 0;
            cut           = 1'b0;
            errors        = 0;
            bytes_checked = 0;
        endfunction

        function void set_mask(cfg_index_t idx, logic [63:0] value);
            case (idx)
                REG_BRACKET_LO:  brk_lo = value;
                REG_BRACKET_HI:  brk_hi = value;
                REG_OPERATOR_LO: op_lo  = value;
                REG_OPERATOR_HI: op_hi  = value;
                default:         ;
            endcase
        endfunction

        // Appends one expected byte at the tail of the expected stream.
        function void add_expected(token_beat_t beat);
            pending_tokens.insert(pending_tokens.size(), beat);
        endfunction

        // Codes of 128 and up are in no set.
        function bit in_mask(logic [63:0] lo, logic [63:0] hi, logic [7:0] c);
            if (c[7])
                return 1'b0;
            return c[6] ? hi[c[5:0]] : lo[c[5:0]];
        endfunction

        // Replay the open token into the expected stream and empty the buffer.
        function void flush_open();
            token_beat_t beat;
            int unsigned i;
            case (open_mode)
                MODE_NUMBER: beat.kind = KIND_NUMBER;
                MODE_OPER:   beat.kind = KIND_OPER;
                default:     beat.kind = KIND_IDENT;
            endcase
            if (open_mode != MODE_NORMAL)
            begin
                for (i = 0; i < held_len; i++)
                begin
                    beat.value = held[i];
                    beat.last  = (i + 1 == held_len);
                    beat.cut   = cut;
                    add_expected(beat);
                end
            end
            held_len = 0;
            cut      = 1'b0;
        endfunction

        // Called for each accepted character; returns 1 unless the character is ignored.
        function bit note_char(logic [7:0] c, logic eot);
            mode_t       next_mode;
            bit          brk;
            bit          semi;
            bit          digit;
            bit          alpha;
            bit          effective;
            token_beat_t beat;
            next_mode = open_mode;
            brk       = 1'b0;
            semi      = 1'b0;
            digit     = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
            alpha     = ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
                        ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z));

            // First matching class wins; a digit inside an identifier stays in it.
            if (in_mask(brk_lo, brk_hi, c))
                brk = 1'b1;
            else if (digit && open_mode != MODE_IDENT)
                next_mode = MODE_NUMBER;
            else if (alpha || digit || c == CHAR_UNDERSCORE)
                next_mode = MODE_IDENT;
            else if (in_mask(op_lo, op_hi, c))
                next_mode = MODE_OPER;
            else if (c == CHAR_SEMI)
                semi = 1'b1;
            else if (c == CHAR_SPACE || c == CHAR_NEWLINE || c == CHAR_TAB)
                next_mode = MODE_NORMAL;
            if (brk || semi)
                next_mode = MODE_NORMAL;

            effective = brk || semi || (next_mode != open_mode) || (next_mode != MODE_NORMAL);

            if (brk || semi || next_mode != open_mode)
                flush_open();
            open_mode = next_mode;

            // Append to the open token, or note that a byte was lost.
            if (open_mode != MODE_NORMAL)
            begin
                if (held_len < MAX_TOKEN_LEN)
                begin
                    held[held_len] = c;
                    held_len++;
                end
                else
                    cut = 1'b1;
            end

            beat.last = 1'b1;
            beat.cut  = 1'b0;
            if (brk)
            begin
                beat.kind  = KIND_BRACKET;
                beat.value = c;
                add_expected(beat);
            end
            else if (semi)
            begin
                beat.kind  = KIND_SEMI;
                beat.value = CHAR_SEMI;
                add_expected(beat);
            end

            if (eot)
            begin
                flush_open();
                open_mode = MODE_NORMAL;
            end
            return effective;
        endfunction

        function void report(string field, logic [7:0] want_v, logic [7:0] got_v);
            errors++;
            $display("%0t: %s mismatch, expected %02h, got %02h", $time, field, want_v, got_v);
        endfunction

        // Called for each accepted token byte.
        function void check_token(logic [2:0] kind, logic [7:0] value, logic last,
                                  logic cut_flag);
            token_beat_t want;
            if (pending_tokens.size() == 0)
            begin
                errors++;
                $display("%0t: token byte with nothing expected, expected none, got kind %0d byte %02h",
                         $time, kind, value);
                return;
            end
            want = pending_tokens.pop_front();
            bytes_checked++;
            if (want.kind !== kind)
                report("token_kind", want.kind, kind);
            if (want.value !== value)
                report("token_byte", want.value, value);
            if (want.last !== last)
                report("token_last", want.last, last);
            if (want.cut !== cut_flag)
                report("token_truncated", want.cut, cut_flag);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    cct_char_if  char_ch ();
    cct_token_if tok_ch ();

    token_scoreboard sb;
    int unsigned     cycles = 0;
    int unsigned     chars_sent = 0;
    int unsigned     chars_counted = 0;
    int unsigned     settings_used = 0;
    int              send_gap_max = 15;
    int              take_gap_max = 15;
    bit              hold_req = 1'b0;

    char_class_tokenizer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_in   (char_ch),
        .token_out (tok_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 100 MHz clock.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d token bytes outstanding.",
                     cycles, sb.pending_tokens.size());
            $display("tb: FAIL");
            $finish;
        end
    end

    // Random member of a character set, or any 7-bit code when the set looks empty.
    function automatic logic [7:0] pick_member(logic [63:0] lo, logic [63:0] hi);
        logic [7:0] c;
        int         tries;
        c = 8'($urandom_range(0, 127));
        for (tries = 0; tries < 64; tries++)
        begin
            if (c[6] ? hi[c[5:0]] : lo[c[5:0]])
                return c;
            c = 8'($urandom_range(0, 127));
        end
        return c;
    endfunction

    // Offer one character after a random gap and wait for its transaction.
    // Starts and ends at a rising edge.
    task automatic send_char(input logic [7:0] c, input logic eot);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            char_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_ch.valid       <= 1'b1;
        char_ch.char_code   <= c;
        char_ch.end_of_text <= eot;
        do
            @(posedge clk);
        while (char_ch.ready !== 1'b1);
        if (sb.note_char(c, eot))
            chars_counted++;
        chars_sent++;
    endtask

    // One lexical unit with random content: identifier, number, operator run, bracket,
    // semicolon, whitespace or a noise byte. Long runs overflow the token buffer.
    task automatic send_word(input bit force_long);
        int         pick;
        int         len;
        int         i;
        int         r;
        logic [7:0] c;
        logic       eot_end;
        pick = force_long ? 0 : $urandom_range(0, 99);
        len  = 1;
        if (pick < 50)
        begin
            if (force_long || $urandom_range(0, 19) == 0)
                len = $urandom_range(33, 40);
            else
                len = $urandom_range(1, 6);
        end
        else if (pick < 65 || (pick >= 80 && pick < 90))
            len = $urandom_range(1, 3);
        eot_end = ($urandom_range(0, 7) == 0);
        for (i = 0; i < len; i++)
        begin
            r = $urandom_range(0, 9);
            if (pick < 30)
            begin
                if (r < 6 || (i == 0 && r < 9))
                    c = ($urandom_range(0, 1) ? CHAR_LOWER_A : CHAR_UPPER_A) +
                        8'($urandom_range(0, 25));
                else if (r < 9)
                    c = CHAR_ZERO + 8'($urandom_range(0, 9));
                else
                    c = CHAR_UNDERSCORE;
            end
            else if (pick < 50)
                c = CHAR_ZERO + 8'($urandom_range(0, 9));
            else if (pick < 65)
                c = pick_member(sb.op_lo, sb.op_hi);
            else if (pick < 73)
                c = pick_member(sb.brk_lo, sb.brk_hi);
            else if (pick < 80)
                c = CHAR_SEMI;
            else if (pick < 90)
                c = (r < 4) ? CHAR_SPACE : ((r < 7) ? CHAR_NEWLINE : CHAR_TAB);
            else
                c = 8'($urandom_range(0, 255));
            send_char(c, eot_end && (i == len - 1));
        end
    endtask

    // Random text until the given number of characters with an effect went in.
    task automatic run_phase(input int unsigned target, input bit force_long);
        int unsigned start;
        start = chars_counted;
        send_word(force_long);
        while (chars_counted - start < target)
            send_word(1'b0);
    endtask

    // Stop offering, wait for every expected byte, then let the block drain.
    task automatic settle();
        char_ch.valid <= 1'b0;
        while (sb.pending_tokens.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all four class masks, one register per cycle.
    task automatic write_masks(input logic [63:0] b_lo, input logic [63:0] b_hi,
                               input logic [63:0] o_lo, input logic [63:0] o_hi);
        cfg_index_t  idx;
        logic [63:0] value;
        idx = REG_BRACKET_LO;
        repeat (4)
        begin
            case (idx)
                REG_BRACKET_LO:  value = b_lo;
                REG_BRACKET_HI:  value = b_hi;
                REG_OPERATOR_LO: value = o_lo;
                default:         value = o_hi;
            endcase
            cfg_wr_en <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= value;
            @(posedge clk);
            sb.set_mask(idx, value);
            idx = idx.next();
        end
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // Token receiver: random stalls per transaction, one long hold-off on request.
    initial
    begin
        int stall;
        tok_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            else
                stall = $urandom_range(0, take_gap_max);
            if (stall > 0)
            begin
                tok_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            tok_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (tok_ch.valid !== 1'b1);
            sb.check_token(tok_ch.token_kind, tok_ch.token_byte, tok_ch.token_last,
                           tok_ch.token_truncated);
        end
    end

    // Stimulus and verdict.
    initial
    begin
        logic [8:0] directed_seq [$];
        int         i;
        sb                  = new();
        rst_n               = 1'b0;
        char_ch.valid       = 1'b0;
        char_ch.char_code   = 8'h00;
        char_ch.end_of_text = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_index           = REG_BRACKET_LO;
        cfg_data            = 64'd0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed text: code extremes, dropped and high bytes, digit inside an
        // identifier, letter after a number, every token kind, end of text.
        directed_seq = '{{1'b0, 8'h00}, {1'b0, 8'h80}, {1'b0, "a"}, {1'b0, "1"},
                         {1'b0, "_"}, {1'b0, "Z"}, {1'b0, 8'hFF}, {1'b0, " "},
                         {1'b0, "1"}, {1'b0, "2"}, {1'b0, "x"}, {1'b0, "+"},
                         {1'b0, "="}, {1'b0, "("}, {1'b0, "7"}, {1'b0, ";"},
                         {1'b0, 8'h09}, {1'b0, "}"}, {1'b0, 8'h7F}, {1'b0, 8'h0A},
                         {1'b1, "q"}, {1'b1, "5"}, {1'b1, 8'h01}, {1'b1, "["}};
        for (i = 0; i < directed_seq.size(); i++)
            send_char(directed_seq[i][7:0], directed_seq[i][8]);

        // Default masks, with an overlong identifier first.
        run_phase(70, 1'b1);
        settle();

        // No brackets and no operators.
        write_masks(64'd0, 64'd0, 64'd0, 64'd0);
        run_phase(45, 1'b0);
        settle();

        // Every other code is an operator; no idling on either side.
        send_gap_max = 0;
        take_gap_max = 0;
        write_masks(64'd0, 64'd0, {64{1'b1}}, {64{1'b1}});
        run_phase(45, 1'b0);
        settle();

        // Every 7-bit code is a bracket.
        send_gap_max = 15;
        take_gap_max = 15;
        write_masks({64{1'b1}}, {64{1'b1}}, {$urandom, $urandom}, {$urandom, $urandom});
        run_phase(25, 1'b0);
        settle();

        // Random masks.
        write_masks({$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom});
        run_phase(50, 1'b0);
        settle();

        // Back to defaults; the receiver holds off while characters keep coming.
        write_masks(BRACKET_LO_RESET, BRACKET_HI_RESET, OPERATOR_LO_RESET, OPERATOR_HI_RESET);
        send_gap_max = 0;
        hold_req     = 1'b1;
        run_phase(55, 1'b1);
        settle();

        $display("Sent %0d characters (%0d not ignored) under %0d mask settings plus reset.",
                 chars_sent, chars_counted, settings_used);
        $display("Checked %0d token bytes, %0d mismatches.", sb.bytes_checked, sb.errors);
        if (sb.errors == 0 && sb.pending_tokens.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
